>>> rtl/ftqg_pkg.sv
// Shared types, constants and helper functions of the frame time quality governor.
// No dependencies; used by ftqg_adapt and frame_time_quality_governor.

package ftqg_pkg;

    // Quality levels and the automatic mode code
    localparam logic [1:0] LVL_QUALITY  = 2'd0;
    localparam logic [1:0] LVL_BALANCED = 2'd1;
    localparam logic [1:0] LVL_LOW      = 2'd2;
    localparam logic [1:0] MODE_AUTO    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_QUALITY_MODE = 3'd0;
    localparam logic [2:0] CFG_MIN_SCALE    = 3'd1;
    localparam logic [2:0] CFG_MAX_SCALE    = 3'd2;
    localparam logic [2:0] CFG_LIGHT_CAP    = 3'd3;
    localparam logic [2:0] CFG_INIT_FT      = 3'd4;
    localparam logic [2:0] CFG_PROMOTE_THR  = 3'd5;
    localparam logic [2:0] CFG_DEGRADE_THR  = 3'd6;

    // Register reset values
    localparam logic [1:0]  RST_MODE        = MODE_AUTO;
    localparam logic [9:0]  RST_MIN_SCALE   = 10'd650;
    localparam logic [9:0]  RST_MAX_SCALE   = 10'd1000;
    localparam logic [7:0]  RST_LIGHT_CAP   = 8'd2;
    localparam logic [17:0] RST_INIT_FT     = 18'd8533;
    localparam logic [17:0] RST_PROMOTE_THR = 18'd5632;
    localparam logic [17:0] RST_DEGRADE_THR = 18'd8704;

    localparam logic [17:0] FT_MAX        = 18'd256000;
    localparam logic [4:0]  DEGRADE_COUNT = 5'd18;
    localparam logic [7:0]  PROMOTE_COUNT = 8'd240;

    localparam logic [9:0]  DIST_FULL  = 10'd1000;
    localparam logic [9:0]  DIST_FLOOR = 10'd500;
    localparam logic [9:0]  DIST_STEP_LIMIT = 10'd510;
    localparam logic [9:0]  DIST_HALVE = 10'd640;
    localparam logic [9:0]  SCALE_DECREMENT = 10'd50;
    localparam logic [10:0] SHADOW_HI  = 11'd1024;
    localparam logic [10:0] SHADOW_LO  = 11'd512;
    localparam logic [3:0]  TAPS_HI    = 4'd9;
    localparam logic [3:0]  TAPS_LO    = 4'd4;

    typedef struct packed {
        logic [1:0]  level;
        logic [10:0] shadow;
        logic [1:0]  casc;
        logic [3:0]  taps;
        logic [7:0]  lights;
        logic [9:0]  scale;
        logic [9:0]  dist_scale;
    } t_settings;

    typedef struct packed {
        logic [9:0] min_rs;
        logic [9:0] max_rs;
        logic [7:0] cap;
    } t_limits;

    function automatic logic [9:0] umin10(input logic [9:0] a, input logic [9:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [9:0] umax10(input logic [9:0] a, input logic [9:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [9:0] lvl_min_scale(input logic [1:0] l);
        logic [9:0] v;
        unique case (l)
            LVL_QUALITY:  v = 10'd850;
            LVL_BALANCED: v = 10'd750;
            default:      v = 10'd650;
        endcase
        return v;
    endfunction

    function automatic logic [9:0] lvl_max_scale(input logic [1:0] l);
        return (l >= LVL_LOW) ? 10'd850 : 10'd1000;
    endfunction

    // Full preset settings for a level
    function automatic t_settings preset(input logic [1:0] l, input t_limits lim);
        t_settings s;
        logic [7:0] two_cap;
        logic [7:0] one_cap;
        two_cap = (lim.cap < 8'd2) ? lim.cap : 8'd2;
        one_cap = (lim.cap < 8'd1) ? lim.cap : 8'd1;
        s.level = l;
        s.dist_scale = DIST_FULL;
        if (l == LVL_QUALITY) begin
            s.shadow = SHADOW_HI; s.casc = 2'd2; s.taps = TAPS_HI; s.lights = two_cap;
        end else if (l == LVL_BALANCED) begin
            s.shadow = SHADOW_HI; s.casc = 2'd1; s.taps = TAPS_LO; s.lights = two_cap;
        end else begin
            s.shadow = SHADOW_LO; s.casc = 2'd1; s.taps = TAPS_LO; s.lights = one_cap;
        end
        s.scale = umin10(lim.max_rs, lvl_max_scale(l));
        return s;
    endfunction

    // Render scale clamped into the window of a level
    function automatic logic [9:0] clamp_scale(input logic [9:0] v, input logic [1:0] l,
                                               input t_limits lim);
        logic [9:0] lo;
        logic [9:0] hi;
        logic [9:0] flo;
        lo  = umax10(lim.min_rs, lvl_min_scale(l));
        hi  = umin10(lim.max_rs, lvl_max_scale(l));
        flo = umin10(lo, hi);
        if (v < flo) return flo;
        if (v > hi)  return hi;
        return v;
    endfunction

endpackage

>>> rtl/ftqg_adapt.sv
// Next-settings logic: one degrade step in priority order, or one preset promotion.
// Depends on ftqg_pkg.

module ftqg_adapt (
    input  ftqg_pkg::t_settings i_cur,
    input  ftqg_pkg::t_limits   i_lim,
    input  logic                i_degrade,
    input  logic                i_promote,
    output ftqg_pkg::t_settings o_next
);

    logic [9:0]  w_minimum;
    logic [9:0]  w_scale_dn;
    logic [23:0] w_dist_prod;
    logic [9:0]  w_dist_q;
    logic [9:0]  w_dist_new;

    assign w_minimum  = ftqg_pkg::umax10(i_lim.min_rs, ftqg_pkg::lvl_min_scale(i_cur.level));
    assign w_scale_dn = ftqg_pkg::umax10(w_minimum, i_cur.scale - ftqg_pkg::SCALE_DECREMENT);

    // dist*4/5: reciprocal 3277/2^14 is exact for dividends below 16384
    assign w_dist_prod = 24'({i_cur.dist_scale, 2'b00}) * 24'd3277;
    assign w_dist_q    = w_dist_prod[23:14];
    assign w_dist_new  = (w_dist_q < ftqg_pkg::DIST_FLOOR) ? ftqg_pkg::DIST_FLOOR : w_dist_q;

    always_comb begin
        o_next = i_cur;
        if (i_degrade) begin
            priority if (i_cur.scale > w_minimum) begin
                o_next.scale = w_scale_dn;
            end else if (i_cur.taps > ftqg_pkg::TAPS_LO) begin
                o_next.taps = ftqg_pkg::TAPS_LO;
            end else if (i_cur.dist_scale > ftqg_pkg::DIST_STEP_LIMIT) begin
                o_next.dist_scale = w_dist_new;
                if (i_cur.shadow > ftqg_pkg::SHADOW_LO && w_dist_new <= ftqg_pkg::DIST_HALVE) begin
                    o_next.shadow = {1'b0, i_cur.shadow[10:1]};
                    o_next.casc   = 2'd1;
                end
            end else if (i_cur.lights > 8'd1) begin
                o_next.lights = 8'd1;
            end else if (i_cur.level == ftqg_pkg::LVL_QUALITY) begin
                o_next.level = ftqg_pkg::LVL_BALANCED;
                o_next.casc  = 2'd1;
                o_next.taps  = ftqg_pkg::TAPS_LO;
                if (i_cur.shadow > ftqg_pkg::SHADOW_HI)
                    o_next.shadow = ftqg_pkg::SHADOW_HI;
                if (i_cur.lights > 8'd2)
                    o_next.lights = 8'd2;
                if (o_next.lights > i_lim.cap)
                    o_next.lights = i_lim.cap;
                o_next.scale = ftqg_pkg::clamp_scale(i_cur.scale, ftqg_pkg::LVL_BALANCED, i_lim);
            end else if (i_cur.level == ftqg_pkg::LVL_BALANCED) begin
                o_next.level = ftqg_pkg::LVL_LOW;
                o_next.casc  = 2'd1;
                o_next.taps  = ftqg_pkg::TAPS_LO;
                if (i_cur.shadow > ftqg_pkg::SHADOW_LO)
                    o_next.shadow = ftqg_pkg::SHADOW_LO;
                if (i_cur.lights > 8'd1)
                    o_next.lights = 8'd1;
                o_next.scale = ftqg_pkg::clamp_scale(i_cur.scale, ftqg_pkg::LVL_LOW, i_lim);
            end else begin
                o_next = i_cur;
            end
        end else if (i_promote) begin
            if (i_cur.level == ftqg_pkg::LVL_LOW)
                o_next = ftqg_pkg::preset(ftqg_pkg::LVL_BALANCED, i_lim);
            else if (i_cur.level == ftqg_pkg::LVL_BALANCED)
                o_next = ftqg_pkg::preset(ftqg_pkg::LVL_QUALITY, i_lim);
        end
    end

endmodule

>>> rtl/frame_time_quality_governor.sv
// Top level of the frame time quality governor: stream ports, configuration registers,
// frame-time averages, budget counters and settings state. Depends on ftqg_pkg, ftqg_adapt.

// One frame-time sample per transaction; one result per sample. The block takes a sample
// every cycle unless stalled and registers it in the input register, then the result
// register; the average update and adaptation step are a single pass of logic between
// them. Back-pressure on the result side stalls both stages. Any configuration write to
// a listed register restarts the governor (averages, counters, preset, changed flag set)
// with the written values in the same cycle; the configuration channel is always ready.

module frame_time_quality_governor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // frame_time[17:0], clear_change[18], zero fill
    input  logic [1:0]  i_s_axis_tuser,  // source_is_cpu[0], timer_disjoint[1]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,  // active_preset[1:0], shadow_resolution[12:2],
                                         // cascade_count[14:13], filter_taps[18:15],
                                         // point_lights[26:19], render_scale[36:27],
                                         // shadow_distance[46:37], quality_changed[47],
                                         // sample_used[48], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [17:0] i_cfg_data
);

    // Configuration registers
    logic [1:0]  r_mode, n_mode;
    logic [9:0]  r_min_rs, n_min_rs;
    logic [9:0]  r_max_rs, n_max_rs;
    logic [7:0]  r_cap, n_cap;
    logic [17:0] r_init_ft, n_init_ft;
    logic [17:0] r_promote_thr, n_promote_thr;
    logic [17:0] r_degrade_thr, n_degrade_thr;
    logic        w_cfg_restart;

    // Governor state
    logic [27:0]         r_gpu_avg, n_gpu_avg;
    logic [27:0]         r_cpu_avg, n_cpu_avg;
    logic [7:0]          r_headroom, n_headroom;
    logic [4:0]          r_gpu_over, n_gpu_over;
    logic [4:0]          r_cpu_over, n_cpu_over;
    ftqg_pkg::t_settings r_set, n_set, w_restart_set;
    logic                r_changed, n_changed;

    // Input and result stages
    logic        r_in_valid;
    logic        r_in_cpu;
    logic [17:0] r_in_ft;
    logic        r_in_dis;
    logic        r_in_clr;
    logic        r_out_valid;
    logic [55:0] r_out_data;
    logic        w_adv;
    logic        w_proc;
    logic        w_in_take;

    // Datapath
    ftqg_pkg::t_limits   w_lim, w_lim_new;
    logic                w_used;
    logic [27:0]         w_avg_sel;
    logic signed [28:0]  w_diff;
    logic signed [35:0]  w_prod;
    logic signed [35:0]  w_delta;
    logic [27:0]         w_avg_new;
    logic                w_over;
    logic                w_under;
    logic [4:0]          w_over_inc;
    logic [7:0]          w_head_inc;
    logic                w_degrade;
    logic                w_promote;
    ftqg_pkg::t_settings w_adapt_set;
    logic                w_flag;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_mode        = r_mode;
        n_min_rs      = r_min_rs;
        n_max_rs      = r_max_rs;
        n_cap         = r_cap;
        n_init_ft     = r_init_ft;
        n_promote_thr = r_promote_thr;
        n_degrade_thr = r_degrade_thr;
        w_cfg_restart = 1'b0;
        if (i_cfg_valid) begin
            w_cfg_restart = 1'b1;
            unique case (i_cfg_addr)
                ftqg_pkg::CFG_QUALITY_MODE: n_mode        = i_cfg_data[1:0];
                ftqg_pkg::CFG_MIN_SCALE:    n_min_rs      = i_cfg_data[9:0];
                ftqg_pkg::CFG_MAX_SCALE:    n_max_rs      = i_cfg_data[9:0];
                ftqg_pkg::CFG_LIGHT_CAP:    n_cap         = i_cfg_data[7:0];
                ftqg_pkg::CFG_INIT_FT:      n_init_ft     = i_cfg_data;
                ftqg_pkg::CFG_PROMOTE_THR:  n_promote_thr = i_cfg_data;
                ftqg_pkg::CFG_DEGRADE_THR:  n_degrade_thr = i_cfg_data;
                default:                    w_cfg_restart = 1'b0;
            endcase
        end
    end

    assign w_lim     = '{min_rs: r_min_rs, max_rs: r_max_rs, cap: r_cap};
    assign w_lim_new = '{min_rs: n_min_rs, max_rs: n_max_rs, cap: n_cap};
    assign w_restart_set = ftqg_pkg::preset((n_mode == ftqg_pkg::MODE_AUTO) ?
                                            ftqg_pkg::LVL_LOW : n_mode, w_lim_new);

    // Handshake: a stalled result holds the input stage too
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_proc          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // Average update: avg += floor((ft*1024 - avg) * 82 / 1024)
    assign w_used    = (r_in_ft != 18'd0) && (r_in_ft <= ftqg_pkg::FT_MAX) &&
                       (r_in_cpu || !r_in_dis);
    assign w_avg_sel = r_in_cpu ? r_cpu_avg : r_gpu_avg;
    assign w_diff    = $signed({1'b0, r_in_ft, 10'b0}) - $signed({1'b0, w_avg_sel});
    assign w_prod    = 36'(w_diff) * 36'sd82;
    assign w_delta   = w_prod >>> 10;
    assign w_avg_new = w_avg_sel + w_delta[27:0];
    assign w_over    = w_avg_new > {r_degrade_thr, 10'b0};
    assign w_under   = w_avg_new < {r_promote_thr, 10'b0};
    assign w_over_inc = (r_in_cpu ? r_cpu_over : r_gpu_over) + 5'd1;
    assign w_head_inc = r_headroom + 8'd1;

    always_comb begin
        n_gpu_avg  = r_gpu_avg;
        n_cpu_avg  = r_cpu_avg;
        n_headroom = r_headroom;
        n_gpu_over = r_gpu_over;
        n_cpu_over = r_cpu_over;
        w_degrade  = 1'b0;
        w_promote  = 1'b0;
        if (w_used) begin
            if (r_in_cpu) n_cpu_avg = w_avg_new;
            else          n_gpu_avg = w_avg_new;
            if (r_mode == ftqg_pkg::MODE_AUTO) begin
                if (w_over) begin
                    n_headroom = 8'd0;
                    if (w_over_inc >= ftqg_pkg::DEGRADE_COUNT) begin
                        w_degrade  = 1'b1;
                        n_gpu_over = 5'd0;
                        n_cpu_over = 5'd0;
                    end else if (r_in_cpu) begin
                        n_cpu_over = w_over_inc;
                    end else begin
                        n_gpu_over = w_over_inc;
                    end
                end else begin
                    if (r_in_cpu) begin
                        n_cpu_over = 5'd0;
                    end else begin
                        n_gpu_over = 5'd0;
                        if (w_under) begin
                            if (w_head_inc >= ftqg_pkg::PROMOTE_COUNT) begin
                                w_promote  = 1'b1;
                                n_headroom = 8'd0;
                            end else begin
                                n_headroom = w_head_inc;
                            end
                        end else begin
                            n_headroom = 8'd0;
                        end
                    end
                end
            end
        end
    end

    ftqg_adapt u_adapt (
        .i_cur     (r_set),
        .i_lim     (w_lim),
        .i_degrade (w_degrade),
        .i_promote (w_promote),
        .o_next    (w_adapt_set)
    );

    assign n_set     = w_adapt_set;
    assign w_flag    = r_changed || (w_adapt_set != r_set);
    assign n_changed = r_in_clr ? 1'b0 : w_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ftqg_pkg::RST_MODE;
            r_min_rs      <= ftqg_pkg::RST_MIN_SCALE;
            r_max_rs      <= ftqg_pkg::RST_MAX_SCALE;
            r_cap         <= ftqg_pkg::RST_LIGHT_CAP;
            r_init_ft     <= ftqg_pkg::RST_INIT_FT;
            r_promote_thr <= ftqg_pkg::RST_PROMOTE_THR;
            r_degrade_thr <= ftqg_pkg::RST_DEGRADE_THR;
            r_gpu_avg     <= {ftqg_pkg::RST_INIT_FT, 10'b0};
            r_cpu_avg     <= {ftqg_pkg::RST_INIT_FT, 10'b0};
            r_headroom    <= 8'd0;
            r_gpu_over    <= 5'd0;
            r_cpu_over    <= 5'd0;
            r_set         <= ftqg_pkg::preset(ftqg_pkg::LVL_LOW,
                                 '{min_rs: ftqg_pkg::RST_MIN_SCALE,
                                   max_rs: ftqg_pkg::RST_MAX_SCALE,
                                   cap:    ftqg_pkg::RST_LIGHT_CAP});
            r_changed     <= 1'b1;
        end else begin
            r_mode        <= n_mode;
            r_min_rs      <= n_min_rs;
            r_max_rs      <= n_max_rs;
            r_cap         <= n_cap;
            r_init_ft     <= n_init_ft;
            r_promote_thr <= n_promote_thr;
            r_degrade_thr <= n_degrade_thr;
            if (w_cfg_restart) begin
                r_gpu_avg  <= {n_init_ft, 10'b0};
                r_cpu_avg  <= {n_init_ft, 10'b0};
                r_headroom <= 8'd0;
                r_gpu_over <= 5'd0;
                r_cpu_over <= 5'd0;
                r_set      <= w_restart_set;
                r_changed  <= 1'b1;
            end else if (w_proc) begin
                r_gpu_avg  <= n_gpu_avg;
                r_cpu_avg  <= n_cpu_avg;
                r_headroom <= n_headroom;
                r_gpu_over <= n_gpu_over;
                r_cpu_over <= n_cpu_over;
                r_set      <= n_set;
                r_changed  <= n_changed;
            end
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready)
                r_in_valid <= i_s_axis_tvalid;
            if (w_adv)
                r_out_valid <= r_in_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_cpu <= i_s_axis_tuser[0];
            r_in_dis <= i_s_axis_tuser[1];
            r_in_ft  <= i_s_axis_tdata[17:0];
            r_in_clr <= i_s_axis_tdata[18];
        end
        if (w_proc) begin
            r_out_data <= {7'b0, w_used, w_flag, n_set.dist_scale, n_set.scale, n_set.lights,
                           n_set.taps, n_set.casc, n_set.shadow, n_set.level};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Counters are cleared on reaching their limits
    a_counters_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gpu_over < ftqg_pkg::DEGRADE_COUNT) && (r_cpu_over < ftqg_pkg::DEGRADE_COUNT) &&
        (r_headroom < ftqg_pkg::PROMOTE_COUNT))
        else $error("budget counter reached its limit without being cleared");

    // Fixed modes never change the settings while processing samples
    a_fixed_mode_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && !w_cfg_restart && r_mode != ftqg_pkg::MODE_AUTO) |=> $stable(r_set))
        else $error("settings changed in a fixed quality mode");

    // A rejected sample leaves both averages untouched
    a_rejected_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && !w_used && !w_cfg_restart) |=> ($stable(r_gpu_avg) && $stable(r_cpu_avg)))
        else $error("rejected sample changed an average");

    // A settings change always shows in the reported flag
    a_change_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (n_set != r_set)) |-> w_flag)
        else $error("settings changed without setting the changed flag");

endmodule
